// File: design/peer_sel_pkg.sv
// Package for the peer selector: sequencer states, register map and
// fixed-point constants. No dependencies.
package peer_sel_pkg;

   // Peer table depth and weight format
   localparam int MAX_PEERS        = 256;
   localparam int PEER_W           = 8;
   localparam int WEIGHT_FRAC_BITS = 32;
   localparam int CUM_W            = WEIGHT_FRAC_BITS + 1;  // holds 1.0 exactly
   localparam int SUM_W            = 40;                    // prefix and total sums
   localparam int REM_W            = SUM_W + 1;
   localparam int POW_W            = 24;                    // 255^3 fits
   localparam int WORD_W           = 31;
   localparam int HIT_W            = 32;
   localparam int STEP_W           = 6;

   // Register map (word index on the configuration port)
   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_COUNT = 2'd1;
   localparam logic [1:0] REG_EXP   = 2'd2;

   // Selection modes
   localparam logic [1:0] MODE_UNIFORM = 2'd0;
   localparam logic [1:0] MODE_ZIPF    = 2'd1;
   localparam logic [1:0] MODE_RR      = 2'd2;

   // Reset values of the registers
   localparam logic [1:0] MODE_RESET  = MODE_UNIFORM;
   localparam logic [8:0] COUNT_RESET = 9'd16;
   localparam logic [1:0] EXP_RESET   = 2'd1;

   // What the shared divider is working on
   typedef enum logic [1:0] {
      DIV_MOD = 2'd0,   // random word modulo peer count
      DIV_WGT = 2'd1,   // 2^F / i^alpha
      DIV_CUM = 2'd2    // prefix * 2^F / total
   } div_job_type;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b000000000001,
      ST_POW    = 12'b000000000010,
      ST_DIV    = 12'b000000000100,
      ST_WSTORE = 12'b000000001000,
      ST_PRD    = 12'b000000010000,
      ST_PWAIT  = 12'b000000100000,
      ST_PWR    = 12'b000001000000,
      ST_SRD    = 12'b000010000000,
      ST_SCMP   = 12'b000100000000,
      ST_HRD    = 12'b001000000000,
      ST_HWR    = 12'b010000000000,
      ST_REJ    = 12'b100000000000
   } state_type;

endpackage

// File: design/peer_selector_zipf_uniform_rr.sv
// Peer selector top level: sequencer, shared restoring divider, power
// multiplier, cumulative weight table and per-peer hit counters.
// Depends on peer_sel_pkg.
//
// Uniform mode runs 31 divider steps; Zipf scans the table from peer 1
// up to the selected peer k, where k <= peer_count-1.
// The first Zipf request after reset or a register write also builds the
// table: the weights first, then their normalization, one divider step
// per cycle.
// One request at a time. Synchronous reset clears hit counters at once.
module peer_selector_zipf_uniform_rr
   import peer_sel_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [WORD_W-1:0]   req_random_word,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PEER_W-1:0]   rsp_peer_index,
   output logic [HIT_W-1:0]    rsp_hit_count,
   output logic                rsp_rejected,
   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam logic [CUM_W-1:0] ONE_FIX = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

   // Control registers
   state_type              state_ff, state_in;
   div_job_type            job_ff, job_in;
   logic [1:0]             mode_ff;
   logic [8:0]             count_ff;
   logic [1:0]             exp_ff;
   logic                   ready_ff, ready_in;
   logic [PEER_W-1:0]      rr_ff, rr_in;
   logic [MAX_PEERS-1:0]   hv_ff;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [WORD_W-1:0]      word_ff, word_in;
   logic [PEER_W-1:0]      idx_ff, idx_in;
   logic [PEER_W-1:0]      peer_ff, peer_in;
   logic [POW_W-1:0]       pow_ff, pow_in;
   logic [1:0]             k_ff, k_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [SUM_W-1:0]       den_ff, den_in;
   logic [WORD_W-1:0]      src_ff, src_in;
   logic [CUM_W-1:0]       quo_ff, quo_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [CUM_W-1:0]       w_ff, w_in;
   logic [SUM_W-1:0]       total_ff, total_in;
   logic [SUM_W-1:0]       prefix_ff, prefix_in;
   logic [PEER_W-1:0]      rsp_peer_ff, rsp_peer_in;
   logic [HIT_W-1:0]       rsp_hit_ff, rsp_hit_in;
   logic                   rsp_rej_ff, rsp_rej_in;

   // Memories
   logic [CUM_W-1:0]       cum_mem [MAX_PEERS];
   logic [CUM_W-1:0]       cum_rdata;
   logic                   cum_we;
   logic [PEER_W-1:0]      cum_waddr, cum_raddr;
   logic [CUM_W-1:0]       cum_wdata;
   logic [HIT_W-1:0]       hit_mem [MAX_PEERS];
   logic [HIT_W-1:0]       hit_rdata;
   logic                   hit_we;
   logic [HIT_W-1:0]       hit_wdata;

   // Effective configuration
   logic [8:0]             count_eff;
   logic [PEER_W-1:0]      last_peer;
   logic [1:0]             alpha;
   logic                   cfg_we;

   // Divider step
   logic [REM_W-1:0]       div_sh;
   logic                   div_ge;
   logic [REM_W-1:0]       div_rem;
   logic [CUM_W-1:0]       div_quo;

   logic [SUM_W-1:0]       prefix_sum;
   logic [POW_W+PEER_W-1:0] pow_prod;
   logic                   slot_free;
   logic                   accept;

   assign count_eff = (count_ff < 9'd2) ? 9'd2 :
                      (count_ff > 9'(MAX_PEERS)) ? 9'(MAX_PEERS) : count_ff;
   assign last_peer = PEER_W'(count_eff - 9'd1);
   assign alpha     = (exp_ff == 2'd0) ? 2'd1 : exp_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Configuration port
   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[3:2])
         REG_MODE:  prdata = {30'd0, mode_ff};
         REG_COUNT: prdata = {23'd0, count_ff};
         REG_EXP:   prdata = {30'd0, exp_ff};
         default:   prdata = 32'd0;
      endcase
   end

   // Shared restoring divider step: shifts in one source bit per cycle
   assign div_sh  = {rem_ff[REM_W-2:0], src_ff[WORD_W-1]};
   assign div_ge  = (div_sh >= {1'b0, den_ff});
   assign div_rem = div_ge ? (div_sh - {1'b0, den_ff}) : div_sh;
   assign div_quo = {quo_ff[CUM_W-2:0], div_ge};

   assign pow_prod   = pow_ff * idx_ff;
   assign prefix_sum = prefix_ff + SUM_W'(cum_rdata);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      job_in      = job_ff;
      ready_in    = ready_ff;
      rr_in       = rr_ff;
      word_in     = word_ff;
      idx_in      = idx_ff;
      peer_in     = peer_ff;
      pow_in      = pow_ff;
      k_in        = k_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      src_in      = src_ff;
      quo_in      = quo_ff;
      step_in     = step_ff;
      w_in        = w_ff;
      total_in    = total_ff;
      prefix_in   = prefix_ff;
      rsp_peer_in = rsp_peer_ff;
      rsp_hit_in  = rsp_hit_ff;
      rsp_rej_in  = rsp_rej_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cum_we      = 1'b0;
      cum_waddr   = idx_ff;
      cum_wdata   = quo_ff;
      cum_raddr   = idx_ff;
      hit_we      = 1'b0;
      hit_wdata   = (hv_ff[peer_ff] ? hit_rdata : '0) + HIT_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               word_in = req_random_word;
               if (mode_ff == MODE_ZIPF) begin
                  idx_in = PEER_W'(1);
                  if (req_random_word == '0) begin
                     state_in = ST_REJ;
                  end else if (ready_ff) begin
                     state_in = ST_SRD;
                  end else begin
                     pow_in   = POW_W'(1);
                     k_in     = alpha;
                     total_in = '0;
                     state_in = ST_POW;
                  end
               end else if (mode_ff == MODE_RR) begin
                  peer_in  = (9'(rr_ff) < count_eff) ? rr_ff : '0;
                  rr_in    = (peer_in == last_peer) ? '0 : peer_in + PEER_W'(1);
                  state_in = ST_HRD;
               end else begin
                  rem_in   = '0;
                  src_in   = req_random_word;
                  den_in   = SUM_W'(count_eff);
                  quo_in   = '0;
                  step_in  = STEP_W'(WORD_W);
                  job_in   = DIV_MOD;
                  state_in = ST_DIV;
               end
            end
         end

         // i^alpha, one multiply per cycle
         ST_POW: begin
            if (k_ff != 2'd0) begin
               pow_in = pow_prod[POW_W-1:0];
               k_in   = k_ff - 2'd1;
            end else if (idx_ff == PEER_W'(1)) begin
               w_in     = ONE_FIX;
               state_in = ST_WSTORE;
            end else begin
               rem_in   = REM_W'(1);
               src_in   = '0;
               den_in   = SUM_W'(pow_ff);
               quo_in   = '0;
               step_in  = STEP_W'(WEIGHT_FRAC_BITS);
               job_in   = DIV_WGT;
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            rem_in  = div_rem;
            quo_in  = div_quo;
            src_in  = {src_ff[WORD_W-2:0], 1'b0};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               unique case (job_ff)
                  DIV_MOD: begin
                     peer_in  = div_rem[PEER_W-1:0];
                     state_in = ST_HRD;
                  end
                  DIV_WGT: begin
                     w_in     = div_quo;
                     state_in = ST_WSTORE;
                  end
                  default: state_in = ST_PWR;
               endcase
            end
         end

         // Store raw weight, accumulate the total
         ST_WSTORE: begin
            cum_we    = 1'b1;
            cum_wdata = w_ff;
            total_in  = total_ff + SUM_W'(w_ff);
            if (idx_ff == last_peer) begin
               idx_in    = PEER_W'(1);
               prefix_in = '0;
               state_in  = ST_PRD;
            end else begin
               idx_in   = idx_ff + PEER_W'(1);
               pow_in   = POW_W'(1);
               k_in     = alpha;
               state_in = ST_POW;
            end
         end

         ST_PRD: state_in = ST_PWAIT;

         // Normalize the prefix sum against the total
         ST_PWAIT: begin
            prefix_in = prefix_sum;
            if ((idx_ff == last_peer) || (prefix_sum >= total_ff)) begin
               cum_we    = 1'b1;
               cum_wdata = ONE_FIX;
               if (idx_ff == last_peer) begin
                  ready_in = 1'b1;
                  idx_in   = PEER_W'(1);
                  state_in = ST_SRD;
               end else begin
                  idx_in   = idx_ff + PEER_W'(1);
                  state_in = ST_PRD;
               end
            end else begin
               rem_in   = {1'b0, prefix_sum};
               src_in   = '0;
               den_in   = total_ff;
               quo_in   = '0;
               step_in  = STEP_W'(WEIGHT_FRAC_BITS);
               job_in   = DIV_CUM;
               state_in = ST_DIV;
            end
         end

         ST_PWR: begin
            cum_we   = 1'b1;
            idx_in   = idx_ff + PEER_W'(1);
            state_in = ST_PRD;
         end

         ST_SRD: state_in = ST_SCMP;

         // Inverse CDF scan: first entry at or above the scaled word
         ST_SCMP: begin
            if ((cum_rdata >= {1'b0, word_ff, 1'b0}) || (idx_ff == last_peer)) begin
               peer_in  = idx_ff;
               state_in = ST_HRD;
            end else begin
               idx_in   = idx_ff + PEER_W'(1);
               state_in = ST_SRD;
            end
         end

         ST_HRD: state_in = ST_HWR;

         ST_HWR: begin
            if (slot_free) begin
               hit_we       = 1'b1;
               rsp_peer_in  = peer_ff;
               rsp_hit_in   = hit_wdata;
               rsp_rej_in   = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_REJ: begin
            if (slot_free) begin
               rsp_peer_in  = '0;
               rsp_hit_in   = '0;
               rsp_rej_in   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // any register write invalidates the table
      if (cfg_we && ((paddr[3:2] == REG_MODE) || (paddr[3:2] == REG_COUNT) ||
                     (paddr[3:2] == REG_EXP))) begin
         ready_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= DIV_MOD;
         mode_ff      <= MODE_RESET;
         count_ff     <= COUNT_RESET;
         exp_ff       <= EXP_RESET;
         ready_ff     <= 1'b0;
         rr_ff        <= '0;
         hv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         ready_ff     <= ready_in;
         rr_ff        <= rr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (hit_we) begin
            hv_ff[peer_ff] <= 1'b1;
         end
         if (cfg_we) begin
            unique case (paddr[3:2])
               REG_MODE:  mode_ff  <= pwdata[1:0];
               REG_COUNT: count_ff <= pwdata[8:0];
               REG_EXP:   exp_ff   <= pwdata[1:0];
               default:   ;
            endcase
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      idx_ff      <= idx_in;
      peer_ff     <= peer_in;
      pow_ff      <= pow_in;
      k_ff        <= k_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      src_ff      <= src_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      w_ff        <= w_in;
      total_ff    <= total_in;
      prefix_ff   <= prefix_in;
      rsp_peer_ff <= rsp_peer_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_rej_ff  <= rsp_rej_in;
   end

   // Cumulative weight table
   always_ff @(posedge clock) begin
      if (cum_we) begin
         cum_mem[cum_waddr] <= cum_wdata;
      end
      cum_rdata <= cum_mem[cum_raddr];
   end

   // Hit counters; entries not yet written read as zero through hv_ff
   always_ff @(posedge clock) begin
      if (hit_we) begin
         hit_mem[peer_ff] <= hit_wdata;
      end
      hit_rdata <= hit_mem[peer_ff];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_peer_index = rsp_peer_ff;
   assign rsp_hit_count  = rsp_hit_ff;
   assign rsp_rejected   = rsp_rej_ff;

endmodule

// File: bench/tb_peer_selector_zipf_uniform_rr.sv
// Self-checking bench for the peer selector: directed table, then random
// requests across modes and register settings. Depends on peer_sel_pkg and the RTL.
`timescale 1ns / 1ps

module tb_peer_selector_zipf_uniform_rr
   import peer_sel_pkg::*;
();

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [WORD_W-1:0]   req_random_word;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [PEER_W-1:0]   rsp_peer_index;
   logic [HIT_W-1:0]    rsp_hit_count;
   logic                rsp_rejected;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [3:0]          paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   typedef struct packed {
      logic [PEER_W-1:0] peer;
      logic [HIT_W-1:0]  hits;
      logic              rej;
   } pick_type;

   // directed row: word, whether a typed result is given, and that result
   typedef struct {
      logic [WORD_W-1:0] word;
      bit                typed;
      pick_type          res;
   } dir_row_type;

   peer_selector_zipf_uniform_rr dut (.*);

   // predictor copy of registers and state
   logic [1:0]   mdl_mode;
   logic [8:0]   mdl_count;
   logic [1:0]   mdl_exp;
   logic [7:0]   mdl_rr;
   logic [31:0]  mdl_hits [MAX_PEERS];
   logic [63:0]  mdl_cum [MAX_PEERS];
   bit           mdl_ready;

   pick_type     pending_picks[$];
   int           errors = 0;
   int           quiet = 0;
   bit           in_hold = 0;
   bit           no_idle = 0;
   int           hold_left = 0;
   dir_row_type  dir_rows[$];

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic int clamp_count();
      int c;
      c = mdl_count;
      if (c < 2) c = 2;
      if (c > MAX_PEERS) c = MAX_PEERS;
      return c;
   endfunction

   function automatic void build_cdf(int n, int alpha);
      logic [63:0] total, prefix, d, r, q;
      total = 0;
      prefix = 0;
      for (int i = 1; i <= n; i++) begin
         d = 1;
         for (int k = 0; k < alpha; k++) d = d * i;
         total += (64'd1 << WEIGHT_FRAC_BITS) / d;
      end
      for (int i = 1; i <= n; i++) begin
         d = 1;
         for (int k = 0; k < alpha; k++) d = d * i;
         prefix += (64'd1 << WEIGHT_FRAC_BITS) / d;
         if (i == n || prefix >= total) begin
            mdl_cum[i] = 64'd1 << WEIGHT_FRAC_BITS;
         end else begin
            r = prefix;
            q = 0;
            for (int k = 0; k < WEIGHT_FRAC_BITS; k++) begin
               r = r << 1;
               q = q << 1;
               if (r >= total) begin
                  r -= total;
                  q[0] = 1'b1;
               end
            end
            mdl_cum[i] = q;
         end
      end
      mdl_ready = 1;
   endfunction

   // compute the pick for one request and advance predictor state
   function automatic pick_type select_peer(logic [WORD_W-1:0] word);
      pick_type p;
      int c, n, peer;
      logic [63:0] zf;
      c = clamp_count();
      peer = 0;
      if (mdl_mode == MODE_ZIPF) begin
         n = c - 1;
         if (word == 0) begin
            p.peer = 0; p.hits = 0; p.rej = 1;
            return p;
         end
         if (!mdl_ready) build_cdf(n, (mdl_exp == 0) ? 1 : mdl_exp);
         zf = 64'(word) << (WEIGHT_FRAC_BITS - 31);
         peer = n;
         for (int i = n; i >= 1; i--)
            if (mdl_cum[i] >= zf) peer = i;
      end else if (mdl_mode == MODE_RR) begin
         peer = (mdl_rr < c) ? mdl_rr : 0;
         mdl_rr = (peer + 1 >= c) ? 8'd0 : 8'(peer + 1);
      end else begin
         peer = word % c;
      end
      mdl_hits[peer] += 1;
      p.peer = peer[7:0];
      p.hits = mdl_hits[peer];
      p.rej = 0;
      return p;
   endfunction

   // register write over the configuration port, idle block only
   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (idx)
         REG_MODE:  mdl_mode = val[1:0];
         REG_COUNT: mdl_count = val[8:0];
         REG_EXP:   mdl_exp = val[1:0];
         default: ;
      endcase
      mdl_ready = 0;
   endtask

   task automatic csr_check(logic [1:0] idx, logic [31:0] want);
      psel <= 1; penable <= 0; pwrite <= 0; paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      if (prdata !== want) begin
         $display("%0t csr %0d read: expected %h actual %h", $time, idx, want, prdata);
         errors++;
      end
      psel <= 0; penable <= 0;
   endtask

   // one transfer on the request channel, with random idle before it;
   // valid stays up after the transfer until the next idle or drain
   task automatic send_word(logic [WORD_W-1:0] word, bit typed, pick_type want);
      pick_type p;
      if (!no_idle && $urandom_range(99) < 30) begin
         req_valid <= 0;
         do @(posedge clock); while (!no_idle && $urandom_range(99) < 30);
      end
      req_valid <= 1;
      req_random_word <= word;
      do @(posedge clock); while (req_stall);
      p = select_peer(word);
      if (typed && p !== want) begin
         $display("%0t table row: expected %h actual %h", $time, want, p);
         errors++;
      end
      pending_picks.push_back(p);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // receiver stall, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else if (in_hold) begin
         in_hold <= 0;
         hold_left <= 300;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < 30);
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      pick_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            quiet <= 0;
            if (pending_picks.size() == 0) begin
               $display("%0t unexpected result: expected none actual %h/%h/%b", $time,
                        rsp_peer_index, rsp_hit_count, rsp_rejected);
               errors++;
            end else begin
               want = pending_picks[0];
               pending_picks.delete(0);
               if (rsp_peer_index !== want.peer) begin
                  $display("%0t peer_index: expected %0d actual %0d", $time,
                           want.peer, rsp_peer_index);
                  errors++;
               end
               if (rsp_hit_count !== want.hits) begin
                  $display("%0t hit_count: expected %0d actual %0d", $time,
                           want.hits, rsp_hit_count);
                  errors++;
               end
               if (rsp_rejected !== want.rej) begin
                  $display("%0t rejected: expected %b actual %b", $time,
                           want.rej, rsp_rejected);
                  errors++;
               end
            end
         end else if (req_valid && !req_stall) begin
            quiet <= 0;
         end else begin
            quiet <= quiet + 1;
            if (quiet > 200000) begin
               $display("tb_peer_selector_zipf_uniform_rr: errors");
               $finish;
            end
         end
      end
   end

   function automatic pick_type mk(int peer, int hits, bit rej);
      pick_type p;
      p.peer = peer; p.hits = hits; p.rej = rej;
      return p;
   endfunction

   function automatic void add_row(logic [WORD_W-1:0] w, bit typed, pick_type p);
      dir_row_type r;
      r.word = w; r.typed = typed; r.res = p;
      dir_rows.push_back(r);
   endfunction

   initial begin
      int phase_items;
      logic [WORD_W-1:0] w;
      reset = 1; req_valid = 0; req_random_word = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      mdl_mode = MODE_RESET; mdl_count = COUNT_RESET; mdl_exp = EXP_RESET;
      mdl_rr = 0; mdl_ready = 0;
      for (int i = 0; i < MAX_PEERS; i++) mdl_hits[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset values, uniform mode with 16 peers
      csr_check(REG_MODE, 32'(MODE_RESET));
      csr_check(REG_COUNT, 32'(COUNT_RESET));
      csr_check(REG_EXP, 32'(EXP_RESET));
      add_row(31'd0, 1, mk(0, 1, 0));
      add_row(31'h7FFFFFFF, 1, mk(15, 1, 0));
      add_row(31'd17, 1, mk(1, 1, 0));
      add_row(31'h55555555, 0, mk(0, 0, 0));
      foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);
      dir_rows.delete();
      drain();

      // Zipf at reset exponent: zero word rejected, extremes pick first/last peer
      csr_write(REG_MODE, 32'(MODE_ZIPF));
      add_row(31'd0, 1, mk(0, 0, 1));
      add_row(31'd1, 1, mk(1, 2, 0));
      add_row(31'h7FFFFFFF, 0, mk(0, 0, 0));
      add_row(31'h2AAAAAAA, 0, mk(0, 0, 0));
      foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);
      dir_rows.delete();
      drain();

      // exponent zero, count below range, mode three, round robin with stale pointer
      csr_write(REG_EXP, 0);
      csr_write(REG_COUNT, 0);
      send_word(31'h7FFFFFFF, 1, mk(1, 3, 0));
      drain();
      csr_write(REG_MODE, 3);
      send_word(31'd5, 0, mk(0, 0, 0));
      drain();
      csr_write(REG_MODE, 32'(MODE_RR));
      csr_write(REG_COUNT, 8);
      for (int i = 0; i < 7; i++) send_word($urandom, 0, mk(0, 0, 0));
      drain();
      csr_write(REG_COUNT, 4);
      send_word(31'd9, 0, mk(0, 0, 0));
      send_word(31'd9, 0, mk(0, 0, 0));
      drain();
      csr_write(REG_COUNT, 511);
      csr_write(REG_EXP, 3);
      csr_write(REG_MODE, 32'(MODE_ZIPF));
      send_word(31'h7FFFFFFF, 0, mk(0, 0, 0));
      send_word(31'd1, 0, mk(0, 0, 0));
      drain();

      // random phases over settings
      for (int ph = 0; ph < 29; ph++) begin
         csr_write(REG_MODE, (ph % 4 == 0) ? $urandom : $urandom_range(2));
         case ($urandom_range(4))
            0: csr_write(REG_COUNT, 2);
            1: csr_write(REG_COUNT, 256);
            2: csr_write(REG_COUNT, $urandom);
            default: csr_write(REG_COUNT, $urandom_range(2, 24));
         endcase
         csr_write(REG_EXP, $urandom);
         no_idle = (ph == 5);
         if (ph == 9) in_hold = 1;
         for (int i = 0; i < 50; i++) begin
            case ($urandom_range(9))
               0: w = 0;
               1: w = 31'h7FFFFFFF;
               2: w = $urandom_range(15);
               default: w = $urandom;
            endcase
            send_word(w, 0, mk(0, 0, 0));
         end
         no_idle = 0;
         drain();
      end

      if (errors == 0)
         $display("tb_peer_selector_zipf_uniform_rr: clean");
      else
         $display("tb_peer_selector_zipf_uniform_rr: errors");
      $finish;
   end
endmodule

// File: files.f
design/peer_sel_pkg.sv
design/peer_selector_zipf_uniform_rr.sv
bench/tb_peer_selector_zipf_uniform_rr.sv
